// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LOM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define LOM_NEVER(lbl, clk, rstn, expr) \
    `LOM_ASSERT(lbl, clk, rstn, !(expr))
`else
`define LOM_ASSERT(lbl, clk, rstn, prop)
`define LOM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: rtl/lom_pkg.sv
package lom_pkg;

    localparam int NUM_STOCKS   = 5;
    localparam int BOOK_ENTRIES = 64;
    localparam int NUM_BOOKS    = NUM_STOCKS * 2;
    localparam int TOTAL_SLOTS  = NUM_BOOKS * BOOK_ENTRIES;
    localparam int ADDR_W       = $clog2(TOTAL_SLOTS);
    localparam int SLOT_W       = $clog2(BOOK_ENTRIES);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int BOOK_W       = $clog2(NUM_BOOKS);
    localparam int STK_W        = $clog2(NUM_STOCKS);

    localparam logic [2:0] MODE_BUY    = 3'd0;
    localparam logic [2:0] MODE_SELL   = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [19:0] order;
        logic [15:0] qty;
        logic [19:0] price;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic [15:0] remaining;
        logic [19:0] profit;
        logic        dropped;
    } t_rsp;

endpackage

// File: rtl/lom_if.sv
interface lom_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [19:0] order_id;
    logic [2:0]  stock_index;
    logic [15:0] quantity;
    logic [19:0] limit_price;

    modport source (output valid, mode, order_id, stock_index, quantity, limit_price,
                    input ready);
    modport sink (input valid, mode, order_id, stock_index, quantity, limit_price,
                  output ready);
endinterface

interface lom_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] remaining;
    logic [19:0] profit;
    logic        dropped;

    modport source (output valid, remaining, profit, dropped, input ready);
    modport sink (input valid, remaining, profit, dropped, output ready);
endinterface

// File: rtl/lom_ram.sv
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/lom_ctrl.sv
`include "assert_macros.svh"

module lom_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lom_req_if.sink                     i_req,
    lom_rsp_if.source                   o_rsp,
    output lom_pkg::t_ram_ctl           o_ram,
    input  logic [lom_pkg::ENTRY_W-1:0] i_rdata
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MSCAN = 9'b000000100,
        S_TRADE = 9'b000001000,
        S_RSCAN = 9'b000010000,
        S_REST  = 9'b000100000,
        S_CSCAN = 9'b001000000,
        S_CDEL  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                         r_state;
    logic                           r_buy;
    logic [19:0]                    r_id;
    logic [2:0]                     r_sidx;
    logic [15:0]                    r_qty;
    logic [19:0]                    r_limit;
    logic [lom_pkg::BOOK_W-1:0]     r_book;
    logic [lom_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_pend;
    logic [lom_pkg::ADDR_W-1:0]     r_paddr;
    logic                           r_have;
    lom_pkg::t_entry                r_best;
    logic [lom_pkg::ADDR_W-1:0]     r_best_addr;
    logic [31:0]                    r_arrival;
    logic                           r_traded [lom_pkg::NUM_STOCKS];
    logic [19:0]                    r_low    [lom_pkg::NUM_STOCKS];
    logic [19:0]                    r_rise   [lom_pkg::NUM_STOCKS];
    lom_pkg::t_rsp                  r_res;
    logic [lom_pkg::ADDR_W-1:0]     r_clr_cnt;
    logic                           r_clr_reply;
    logic                           r_out_valid;
    lom_pkg::t_rsp                  r_out;

    lom_pkg::t_entry                q;
    logic [lom_pkg::ADDR_W-1:0]     base;
    logic                           scanning;
    logic                           issue;
    logic                           scan_done;
    logic                           cand;
    logic                           better;
    logic                           take;
    logic                           stock_ok;
    logic [2:0]                     in_sidx;
    logic [lom_pkg::STK_W-1:0]      si;
    logic [19:0]                    new_low;
    logic [19:0]                    rise;
    logic [15:0]                    qty_left;
    logic                           full_fill;
    logic                           out_load;

    assign q         = lom_pkg::t_entry'(i_rdata);
    assign base      = lom_pkg::ADDR_W'(r_book * lom_pkg::BOOK_ENTRIES);
    assign scanning  = (r_state == S_MSCAN) || (r_state == S_RSCAN) || (r_state == S_CSCAN);
    assign issue     = scanning && (r_cnt < lom_pkg::CNT_W'(lom_pkg::BOOK_ENTRIES));
    assign scan_done = scanning && !r_pend
                       && (r_cnt == lom_pkg::CNT_W'(lom_pkg::BOOK_ENTRIES));
    assign stock_ok  = (i_req.stock_index >= 3'd1)
                       && (i_req.stock_index <= 3'(lom_pkg::NUM_STOCKS));
    assign in_sidx   = i_req.stock_index - 3'd1;
    assign si        = r_sidx[lom_pkg::STK_W-1:0];
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        cand   = 1'b0;
        better = 1'b0;
        case (r_state)
            S_MSCAN: begin
                cand   = q.valid && (r_buy ? (q.price <= r_limit) : (q.price >= r_limit));
                better = !r_have || (r_buy ? (q.price < r_best.price) : (q.price > r_best.price))
                         || ((q.price == r_best.price) && (q.stamp < r_best.stamp));
            end
            S_RSCAN: begin
                cand   = !q.valid;
                better = !r_have;
            end
            S_CSCAN: begin
                cand   = q.valid && (q.order == r_id);
                better = !r_have || (q.stamp < r_best.stamp);
            end
            default: begin
                cand   = 1'b0;
                better = 1'b0;
            end
        endcase
    end
    assign take = r_pend && cand && better;

    assign new_low   = (!r_traded[si] || (r_best.price < r_low[si])) ? r_best.price : r_low[si];
    assign rise      = r_best.price - new_low;
    assign full_fill = r_best.qty <= r_qty;
    assign qty_left  = full_fill ? (r_qty - r_best.qty) : 16'd0;

    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.waddr = r_best_addr;
        o_ram.wdata = r_best;
        o_ram.raddr = base + lom_pkg::ADDR_W'(r_cnt[lom_pkg::SLOT_W-1:0]);
        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr_cnt;
                o_ram.wdata = '0;
            end
            S_TRADE: begin
                o_ram.we = 1'b1;
                if (full_fill) begin
                    o_ram.wdata.valid = 1'b0;
                end else begin
                    o_ram.wdata.qty = r_best.qty - r_qty;
                end
            end
            S_REST: begin
                o_ram.we          = r_have;
                o_ram.wdata.valid = 1'b1;
                o_ram.wdata.order = r_id;
                o_ram.wdata.qty   = r_qty;
                o_ram.wdata.price = r_limit;
                o_ram.wdata.stamp = r_arrival;
            end
            S_CDEL: begin
                o_ram.we          = 1'b1;
                o_ram.wdata.valid = 1'b0;
            end
            default: begin
                o_ram.we = 1'b0;
            end
        endcase
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.remaining = r_out.remaining;
    assign o_rsp.profit    = r_out.profit;
    assign o_rsp.dropped   = r_out.dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_cnt       <= '0;
            r_book      <= '0;
            r_arrival   <= '0;
            for (int k = 0; k < lom_pkg::NUM_STOCKS; k++) begin
                r_traded[k] <= 1'b0;
                r_low[k]    <= '0;
                r_rise[k]   <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pend  <= issue;
            r_paddr <= o_ram.raddr;
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (take) begin
                r_have      <= 1'b1;
                r_best      <= q;
                r_best_addr <= r_paddr;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == lom_pkg::ADDR_W'(lom_pkg::TOTAL_SLOTS - 1)) begin
                        r_clr_cnt <= '0;
                        r_state   <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_buy   <= (i_req.mode == lom_pkg::MODE_BUY);
                        r_id    <= i_req.order_id;
                        r_sidx  <= in_sidx;
                        r_qty   <= i_req.quantity;
                        r_limit <= i_req.limit_price;
                        r_cnt   <= '0;
                        r_have  <= 1'b0;
                        case (i_req.mode)
                            lom_pkg::MODE_BUY, lom_pkg::MODE_SELL: begin
                                if (!stock_ok) begin
                                    r_res   <= '{remaining: i_req.quantity, profit: 20'd0,
                                                 dropped: 1'b1};
                                    r_state <= S_DONE;
                                end else if (i_req.quantity != 16'd0) begin
                                    r_res   <= '0;
                                    r_book  <= lom_pkg::BOOK_W'({in_sidx, 1'b0})
                                               + lom_pkg::BOOK_W'(i_req.mode
                                                                  == lom_pkg::MODE_BUY);
                                    r_state <= S_MSCAN;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_DONE;
                                end
                            end
                            lom_pkg::MODE_CANCEL: begin
                                r_res   <= '0;
                                r_book  <= '0;
                                r_state <= S_CSCAN;
                            end
                            lom_pkg::MODE_QUERY: begin
                                r_res   <= '{remaining: 16'd0,
                                             profit: stock_ok
                                                     ? r_rise[in_sidx[lom_pkg::STK_W-1:0]]
                                                     : 20'd0,
                                             dropped: 1'b0};
                                r_state <= S_DONE;
                            end
                            lom_pkg::MODE_CLEAR: begin
                                r_res       <= '0;
                                r_arrival   <= '0;
                                for (int k = 0; k < lom_pkg::NUM_STOCKS; k++) begin
                                    r_traded[k] <= 1'b0;
                                    r_low[k]    <= '0;
                                    r_rise[k]   <= '0;
                                end
                                r_clr_cnt   <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MSCAN: begin
                    if (scan_done) begin
                        if (r_have) begin
                            r_state <= S_TRADE;
                        end else begin
                            r_res.remaining <= r_qty;
                            r_book          <= r_book ^ lom_pkg::BOOK_W'(1);
                            r_cnt           <= '0;
                            r_state         <= S_RSCAN;
                        end
                    end
                end
                S_TRADE: begin
                    r_traded[si] <= 1'b1;
                    r_low[si]    <= new_low;
                    if (rise > r_rise[si]) begin
                        r_rise[si] <= rise;
                    end
                    r_qty  <= qty_left;
                    r_have <= 1'b0;
                    r_cnt  <= '0;
                    if (qty_left == 16'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MSCAN;
                    end
                end
                S_RSCAN: begin
                    if (scan_done) begin
                        r_state <= S_REST;
                    end
                end
                S_REST: begin
                    if (r_have) begin
                        r_arrival <= r_arrival + 32'd1;
                    end else begin
                        r_res.dropped <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_CSCAN: begin
                    if (scan_done) begin
                        if (r_have) begin
                            r_state <= S_CDEL;
                        end else if (r_book == lom_pkg::BOOK_W'(lom_pkg::NUM_BOOKS - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_book <= r_book + 1'b1;
                            r_cnt  <= '0;
                        end
                    end
                end
                S_CDEL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out       <= r_res;
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LOM_ASSERT(a_scan_qty, i_clk, i_rst_n, (r_state == S_MSCAN) |-> (r_qty != 16'd0))
    `LOM_ASSERT(a_trade_shrinks, i_clk, i_rst_n, (r_state == S_TRADE) |=> (r_qty < $past(r_qty)))
    `LOM_NEVER(a_book_range, i_clk, i_rst_n, r_book > lom_pkg::BOOK_W'(lom_pkg::NUM_BOOKS - 1))
endmodule

// File: rtl/limit_order_matcher.sv
// Limit order book matcher for several stocks, one bid and one ask book each.
// Requests arrive on i_req (valid/ready); each accepted transfer yields exactly
// one result transfer on o_rsp: remaining quantity, profit and dropped flag.
// Modes are buy, sell, cancel, profit query and clear.
// Work on a request is sequential through one compare unit and a single-port
// read, single-port write entry memory; a book scan reads each entry in turn.
// A buy or sell scans the opposite book for the best match and trades with it,
// repeating until it fills or finds no match; a remainder then rests in a free
// entry of its own book, or is dropped if none is free. A cancel scans up to
// 10 books; a query or a bad request goes straight to its result. A clear
// writes every one of the 640 entries. After reset the block sweeps the
// entry memory before i_req.ready rises; no result is produced for that sweep.
// A finished result sits in an output register; the block takes the next
// request while it waits. If the receiver stalls, the following result holds
// until the output register empties.
module limit_order_matcher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lom_req_if.sink   i_req,
    lom_rsp_if.source o_rsp
);
    lom_pkg::t_ram_ctl              ram_ctl;
    logic [lom_pkg::ENTRY_W-1:0]    ram_rdata;

    lom_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_ram   (ram_ctl),
        .i_rdata (ram_rdata)
    );

    lom_ram #(
        .WIDTH (lom_pkg::ENTRY_W),
        .DEPTH (lom_pkg::TOTAL_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_ctl.waddr),
        .i_wdata (ram_ctl.wdata),
        .i_raddr (ram_ctl.raddr),
        .o_rdata (ram_rdata)
    );
endmodule
